@@ design/mrpt_pkg.sv @@
// Shared constants of the Miller-Rabin prime test unit
package mrpt_pkg;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned RW = 6;
  localparam logic [RW-1:0] ROUNDS_RESET = 6'd10;
  localparam logic [31:0] LCG_MULT = 32'd69069;
  localparam logic [31:0] LCG_SEED = 32'd1;
endpackage

@@ design/mrpt_if.sv @@
// Valid/ready channel interfaces of the Miller-Rabin prime test unit
interface mrpt_cand_if (input logic clk_i);
  logic                        valid;
  logic                        ready;
  logic [mrpt_pkg::WIDTH-1:0]  candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_res_if (input logic clk_i);
  logic valid;
  logic ready;
  logic probably_prime;
  modport source (output valid, output probably_prime, input ready);
  modport sink (input valid, input probably_prime, output ready);
endinterface

interface mrpt_cfg_if (input logic clk_i);
  logic                      valid;
  logic                      ready;
  logic [mrpt_pkg::RW-1:0]   rounds;
  modport source (output valid, output rounds, input ready);
  modport sink (input valid, input rounds, output ready);
endinterface

@@ design/mrpt_mulmod.sv @@
// Bit-serial modular multiply and reduce (one bit of the multiplier per cycle)
module mrpt_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       red_i,
  input  logic [mrpt_pkg::WIDTH-1:0] a_i,
  input  logic [mrpt_pkg::WIDTH-1:0] b_i,
  input  logic [mrpt_pkg::WIDTH-1:0] m_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [mrpt_pkg::WIDTH-1:0] r_o
);
  localparam int unsigned W = mrpt_pkg::WIDTH;
  localparam int unsigned CNTW = $clog2(W + 1);

  logic [W-1:0]    acc_q, acc_d, b_q, b_d, a_q, m_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      dbl, dbl_r, add, add_r;

  // Horner step: acc = 2*acc mod m, then + a mod m when the multiplier bit is set.
  // Reduce mode uses a = 1, so the bits of b are folded in; result is b mod m.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = CNTW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    if (start_i) begin
      a_q <= red_i ? W'(1) : ((a_i >= m_i) ? a_i - m_i : a_i);
      m_q <= m_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign r_o    = acc_q;
endmodule

@@ design/miller_rabin_prime_test_unit.sv @@
// Top level of the Miller-Rabin prime test unit
// Channels: cand (sink) takes one candidate per request; res (source) returns
// one probably_prime flag per candidate; cfg (sink) writes the rounds register
// (reset 10) at any request; a candidate keeps the round count it was taken with.
// Candidates 0, 1 and even numbers above 2 fail, 2 and 3 pass; the split state
// decides them without a round. Odd candidates strip p-1 to d, one trailing zero
// at a time, then run one round per configured round: a base draw (one bit-serial
// reduction), base^d mod p by square-and-multiply over all 32 exponent bits (32
// squarings plus one product per set bit of d), then up to k-1 squarings.
// One candidate is in work at a time; a new request is taken once the
// previous result has left the output register.
// Reset clears the control, sets rounds to 10 and the base generator state to 1.
// While the receiver stalls the result holds in the output register.
module miller_rabin_prime_test_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  mrpt_cand_if.sink      cand,
  mrpt_res_if.source     res,
  mrpt_cfg_if.sink       cfg
);
  localparam int unsigned W = mrpt_pkg::WIDTH;
  localparam int unsigned BW = $clog2(W);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SPLIT = 9'b000000010,
    S_BASE  = 9'b000000100,
    S_BWAIT = 9'b000001000,
    S_SQ    = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_LOOP  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e               state_q, state_d;
  logic [mrpt_pkg::RW-1:0] rounds_q, rleft_q, rleft_d;
  logic [31:0]          lcg_q, lcg_d;
  logic [W-1:0]         p_q, p_d, d_q, d_d, x_q, x_d, base_q, base_d;
  logic [BW-1:0]        k_q, k_d, i_q, i_d, bit_q, bit_d;
  logic                 res_q, res_d, rvalid_q, rvalid_d;
  logic                 mm_start, mm_red, mm_busy, mm_done;
  logic [W-1:0]         mm_a, mm_b, mm_m, mm_r;
  logic [W-1:0]         pm1;

  assign pm1 = p_q - W'(1);

  mrpt_mulmod u_mm (
    .clk_i, .rst_ni,
    .start_i(mm_start), .red_i(mm_red), .a_i(mm_a), .b_i(mm_b), .m_i(mm_m),
    .busy_o(mm_busy), .done_o(mm_done), .r_o(mm_r)
  );

  assign cand.ready = (state_q == S_IDLE) && !rvalid_q;
  assign cfg.ready  = 1'b1;
  assign res.valid  = rvalid_q;
  assign res.probably_prime = res_q;

  always_comb begin
    state_d = state_q; rleft_d = rleft_q; lcg_d = lcg_q; p_d = p_q; d_d = d_q;
    x_d = x_q; base_d = base_q; k_d = k_q; i_d = i_q; bit_d = bit_q;
    res_d = res_q; rvalid_d = rvalid_q;
    mm_start = 1'b0; mm_red = 1'b0; mm_a = x_q; mm_b = x_q; mm_m = p_q;
    if (rvalid_q && res.ready) rvalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cand.valid && !rvalid_q) begin
          p_d = cand.candidate;
          d_d = cand.candidate - W'(1);
          k_d = '0;
          rleft_d = rounds_q;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (p_q < W'(2)) begin
          res_d = 1'b0; state_d = S_OUT;
        end else if (p_q <= W'(3)) begin
          res_d = 1'b1; state_d = S_OUT;
        end else if (!p_q[0]) begin
          res_d = 1'b0; state_d = S_OUT;
        end else if (!d_q[0]) begin
          d_d = d_q >> 1; k_d = k_q + 1'b1;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (rleft_q == '0) begin
          res_d = 1'b1; state_d = S_OUT;
        end else begin
          rleft_d = rleft_q - 1'b1;
          lcg_d = lcg_q * mrpt_pkg::LCG_MULT;
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        mm_start = 1'b1; mm_red = 1'b1; mm_b = lcg_q; mm_m = p_q - W'(3);
        state_d = S_BWAIT;
      end
      S_BWAIT: begin
        if (mm_done) begin
          base_d = mm_r + W'(2);
          x_d = W'(1);
          bit_d = BW'(W - 1);
          mm_start = 1'b1; mm_a = W'(1); mm_b = W'(1);
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (mm_done) begin
          x_d = mm_r;
          if (d_q[bit_q]) begin
            mm_start = 1'b1; mm_a = mm_r; mm_b = base_q;
            state_d = S_MUL;
          end else if (bit_q == '0) begin
            i_d = BW'(1); state_d = S_CHK;
          end else begin
            bit_d = bit_q - 1'b1;
            mm_start = 1'b1; mm_a = mm_r; mm_b = mm_r;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          x_d = mm_r;
          if (bit_q == '0) begin
            i_d = BW'(1); state_d = S_CHK;
          end else begin
            bit_d = bit_q - 1'b1;
            mm_start = 1'b1; mm_a = mm_r; mm_b = mm_r;
            state_d = S_SQ;
          end
        end
      end
      S_CHK: begin
        if (!mm_busy) begin
          if (mm_done) x_d = mm_r;
          if (i_q == BW'(1) && !mm_done) begin
            if (x_q == W'(1) || x_q == pm1) state_d = S_LOOP;
            else if (i_q >= k_q) begin res_d = 1'b0; state_d = S_OUT; end
            else begin
              mm_start = 1'b1; mm_a = x_q; mm_b = x_q; i_d = i_q + 1'b1;
            end
          end else if (mm_done) begin
            if (mm_r == pm1) state_d = S_LOOP;
            else if (mm_r == W'(1) || i_q >= k_q) begin
              res_d = 1'b0; state_d = S_OUT;
            end else begin
              mm_start = 1'b1; mm_a = mm_r; mm_b = mm_r; i_d = i_q + 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        rvalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rounds_q <= mrpt_pkg::ROUNDS_RESET;
      lcg_q    <= mrpt_pkg::LCG_SEED;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lcg_q    <= lcg_d;
      rvalid_q <= rvalid_d;
      if (cfg.valid) rounds_q <= cfg.rounds;
    end
  end

  always_ff @(posedge clk_i) begin
    rleft_q <= rleft_d; p_q <= p_d; d_q <= d_d; x_q <= x_d; base_q <= base_d;
    k_q <= k_d; i_q <= i_d; bit_q <= bit_d; res_q <= res_d;
  end
endmodule

@@ sim/mrpt_checker.sv @@
// Checker of the Miller-Rabin prime test unit: predicts each verdict and compares
`timescale 1ns / 1ps
module mrpt_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mrpt_cand_if cand,
  mrpt_res_if  res,
  mrpt_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  logic [mrpt_pkg::RW-1:0] rounds_q;
  logic [31:0]   lcg_q;
  bit            verdict_q[$];

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1;
    for (int i = 31; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * b) % m;
    end
    return acc;
  endfunction

  function automatic bit primality_verdict(logic [mrpt_pkg::WIDTH-1:0] cand_v);
    longint unsigned m, d, x, b;
    int k;
    bit hit;
    m = cand_v;
    if (m < 2) return 1'b0;
    if (m <= 3) return 1'b1;
    if (!cand_v[0]) return 1'b0;
    d = m - 1;
    k = 0;
    while (!d[0]) begin
      d = d >> 1;
      k++;
    end
    for (int r = 0; r < rounds_q; r++) begin
      lcg_q = lcg_q * mrpt_pkg::LCG_MULT;
      b = 2 + longint'(lcg_q) % (m - 3);
      x = pow_mod(b, d, m);
      if (x == 1 || x == m - 1) continue;
      hit = 1'b0;
      for (int i = 1; i < k; i++) begin
        x = (x * x) % m;
        if (x == m - 1) begin
          hit = 1'b1;
          break;
        end
        if (x == 1) return 1'b0;
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = verdict_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      rounds_q = mrpt_pkg::ROUNDS_RESET;
      lcg_q    = mrpt_pkg::LCG_SEED;
      verdict_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (res.probably_prime !== want)
            report_mismatch($sformatf("probably_prime %b, predicted %b",
                                      res.probably_prime, want));
        end
      end
      if (cand.valid && cand.ready) verdict_q.push_back(primality_verdict(cand.candidate));
      if (cfg.valid && cfg.ready) rounds_q = cfg.rounds;
    end
  end
endmodule

@@ sim/miller_rabin_prime_test_unit_tb.sv @@
// Testbench top of the Miller-Rabin prime test unit: stimulus and verdict
`timescale 1ns / 1ps
module miller_rabin_prime_test_unit_tb;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   idling;

  mrpt_cand_if cand (clk_i);
  mrpt_res_if  res (clk_i);
  mrpt_cfg_if  cfg (clk_i);

  miller_rabin_prime_test_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand   (cand),
    .res    (res),
    .cfg    (cfg)
  );

  mrpt_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand       (cand),
    .res        (res),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 3) == 0) begin
        res.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      res.ready = 1'b1;
    end
  end

  task automatic send_request(logic [mrpt_pkg::WIDTH-1:0] value);
    if (idling && $urandom_range(0, 3) == 0) begin
      cand.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    cand.valid     = 1'b1;
    cand.candidate = value;
    do @(posedge clk_i); while (!cand.ready);
    @(negedge clk_i);
  endtask

  task automatic write_rounds(logic [mrpt_pkg::RW-1:0] value);
    cand.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg.valid  = 1'b1;
    cfg.rounds = value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [mrpt_pkg::WIDTH-1:0] random_candidate();
    logic [mrpt_pkg::WIDTH-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0:       v[0] = 1'b0;
      1:       v = $urandom_range(0, 63);
      2:       ;
      default: v[0] = 1'b1;
    endcase
    return v;
  endfunction

  initial begin
    logic [mrpt_pkg::WIDTH-1:0] directed[$];
    idling         = 1'b1;
    cand.valid     = 1'b0;
    cand.candidate = '0;
    cfg.valid      = 1'b0;
    cfg.rounds     = '0;
    rst_ni         = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd561,
                 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h8000_0000, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h8000_0001};
    foreach (directed[i]) send_request(directed[i]);

    write_rounds(6'd0);
    repeat (10) send_request(random_candidate());
    send_request(32'hFFFF_FFFB);

    write_rounds(6'd63);
    foreach (directed[i]) if (directed[i] < 32'd600) send_request(directed[i]);
    repeat (4) send_request($urandom_range(5, 255));

    for (int blk = 0; blk < 5; blk++) begin
      write_rounds(mrpt_pkg::RW'($urandom_range(1, 4)));
      if (blk == 4) idling = 1'b0;
      repeat (20) send_request(random_candidate());
    end
    cand.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ miller_rabin_prime_test_unit.f @@
design/mrpt_pkg.sv
design/mrpt_if.sv
design/mrpt_mulmod.sv
design/miller_rabin_prime_test_unit.sv
sim/mrpt_checker.sv
sim/miller_rabin_prime_test_unit_tb.sv
